// ===== sv/bcd_clock_to_epoch_nanoseconds_defines.svh =====
// ----------------------------------------------------------------------------
// bcd_clock_to_epoch_nanoseconds_defines.svh
// Assertion macros for the RTC snapshot to epoch converter.
// ----------------------------------------------------------------------------
`ifndef BCD_CLOCK_TO_EPOCH_NANOSECONDS_DEFINES_SVH
`define BCD_CLOCK_TO_EPOCH_NANOSECONDS_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define BCD2NS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bcd2ns assertion failed");

// next-cycle implication
`define BCD2NS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bcd2ns assertion failed");

`endif

// ===== sv/bcd2ns_pkg.sv =====
// ----------------------------------------------------------------------------
// bcd2ns_pkg
// Constants and day-of-year table for the RTC snapshot to epoch converter.
// ----------------------------------------------------------------------------
`default_nettype none

package bcd2ns_pkg;

    localparam int unsigned NS_W    = 63;
    localparam int unsigned TOTAL_W = 34;
    localparam int unsigned HALF_W  = 17;
    localparam int unsigned PROD_W  = 47;

    localparam logic [NS_W-1:0]    RESULT_LIMIT = 63'd7400000000000000000;
    localparam logic [TOTAL_W-1:0] SEC_LIMIT    = 34'd7400000000;
    localparam logic [29:0]        NS_PER_SEC   = 30'd1000000000;
    localparam logic [16:0]        SEC_PER_DAY  = 17'd86400;
    // days from 1600-03-01 to 1970-01-01, plus one for the 1-based day of month
    localparam logic [17:0]        DAY_BIAS     = 18'd135081;

    // days from March 1 to the first of month index mp (March = 0)
    function automatic logic [8:0] doy_of(input logic [3:0] mp);
        logic [8:0] d;
        case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== sv/bcd2ns_in_if.sv =====
// ----------------------------------------------------------------------------
// bcd2ns_in_if
// Snapshot channel: six raw RTC time registers with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcd2ns_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] seconds_bcd;
    logic [7:0] minutes_bcd;
    logic [7:0] hours_code;
    logic [7:0] date_bcd;
    logic [7:0] month_century;
    logic [7:0] year_bcd;

    modport source (
        output valid, seconds_bcd, minutes_bcd, hours_code, date_bcd,
               month_century, year_bcd,
        input  ready
    );
    modport sink (
        input  valid, seconds_bcd, minutes_bcd, hours_code, date_bcd,
               month_century, year_bcd,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/bcd2ns_out_if.sv =====
// ----------------------------------------------------------------------------
// bcd2ns_out_if
// Result channel: epoch nanoseconds with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcd2ns_out_if;
    logic        valid;
    logic        ready;
    logic [62:0] epoch_nanoseconds;

    modport source (output valid, epoch_nanoseconds, input ready);
    modport sink   (input valid, epoch_nanoseconds, output ready);
endinterface

`default_nettype wire

// ===== sv/bcd_clock_to_epoch_nanoseconds.sv =====
// ----------------------------------------------------------------------------
// bcd_clock_to_epoch_nanoseconds
// Converts a BCD RTC snapshot to nanoseconds since 1970-01-01 UTC.
// ----------------------------------------------------------------------------
// channel   dir  modport  payload
// i_snap    in   sink     seconds/minutes/hours/date/month_century/year, 8b each
// o_time    out  source   epoch_nanoseconds, 63b
//
// Six-stage pipeline: decode, constant multiplies, day sum, day*86400,
// split 34x30 multiply, recombine/saturate. One transfer per cycle in and
// out while o_time is not stalled. A stall on o_time freezes all stages
// together, and i_snap.ready drops only in reset or while the output stage
// is full and not taken.
// Reset (synchronous, active low) clears the stage valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bcd_clock_to_epoch_nanoseconds_defines.svh"

module bcd_clock_to_epoch_nanoseconds (
    input  wire            i_clk,
    input  wire            i_rst_n,
    bcd2ns_in_if.sink      i_snap,
    bcd2ns_out_if.source   o_time
);

    localparam int unsigned NSTG = 6;

    logic [NSTG-1:0] r_vld;
    logic            w_adv;

    // stage 1
    logic [7:0]  n_sec, r_sec1;
    logic [7:0]  n_min, r_min1;
    logic [5:0]  n_hour, r_hour1;
    logic [5:0]  n_mday, r_mday1;
    logic [9:0]  n_yoff, r_yoff1;
    logic [3:0]  n_mp, r_mp1;
    // stage 2
    logic [17:0] r_y365, r_tsec2, r_tsec3, n_tsec;
    logic [7:0]  r_leap, n_leap;
    logic [8:0]  r_doy;
    logic [5:0]  r_mday2;
    // stage 3
    logic [16:0] r_days;
    // stage 4
    logic [bcd2ns_pkg::TOTAL_W-1:0] r_total;
    // stage 5
    logic [bcd2ns_pkg::PROD_W-1:0]  r_plo, r_phi;
    logic                           r_sat;
    // stage 6
    logic [bcd2ns_pkg::NS_W-1:0]    r_ns;

    logic [5:0]  w_hu;
    logic [4:0]  w_m1;
    logic [3:0]  w_mon;
    logic [9:0]  w_yadj;
    logic [15:0] w_q100p;
    logic [2:0]  w_q100;

    assign w_adv        = !r_vld[NSTG-1] || o_time.ready;
    assign i_snap.ready = w_adv && i_rst_n;
    assign o_time.valid = r_vld[NSTG-1];
    assign o_time.epoch_nanoseconds = r_ns;

    // stage 1 decode
    always_comb begin
        n_sec = 8'(i_snap.seconds_bcd[3:0]) + 8'(i_snap.seconds_bcd[7:4]) * 8'd10;
        n_min = 8'(i_snap.minutes_bcd[3:0]) + 8'(i_snap.minutes_bcd[7:4]) * 8'd10;
        n_mday = 6'(i_snap.date_bcd[3:0]) + 6'(i_snap.date_bcd[5:4]) * 6'd10;

        w_hu = 6'(i_snap.hours_code[3:0]) + (i_snap.hours_code[4] ? 6'd10 : 6'd0);
        n_hour = w_hu;
        if (i_snap.hours_code[6]) begin
            if (w_hu == 6'd12) begin
                n_hour = 6'd0;
            end
            if (i_snap.hours_code[5]) begin
                n_hour = n_hour + 6'd12;
            end
        end else if (i_snap.hours_code[5]) begin
            n_hour = w_hu + 6'd20;
        end

        // month 0..25 raw; w_yadj is year adjust plus one
        w_m1 = 5'(i_snap.month_century[3:0]) + (i_snap.month_century[4] ? 5'd10 : 5'd0);
        if (w_m1 == 5'd0) begin
            w_mon  = 4'd11;
            w_yadj = 10'd0;
        end else if (w_m1 <= 5'd12) begin
            w_mon  = 4'(w_m1 - 5'd1);
            w_yadj = 10'd1;
        end else if (w_m1 <= 5'd24) begin
            w_mon  = 4'(w_m1 - 5'd13);
            w_yadj = 10'd2;
        end else begin
            w_mon  = 4'd0;
            w_yadj = 10'd3;
        end

        // years counted from 1600, March-based
        n_yoff = 10'd400 + 10'(i_snap.year_bcd[3:0]) + 10'(i_snap.year_bcd[7:4]) * 10'd10
               + (i_snap.month_century[7] ? 10'd100 : 10'd0) + w_yadj - 10'd1
               - ((w_mon <= 4'd1) ? 10'd1 : 10'd0);
        n_mp = (w_mon >= 4'd2) ? (w_mon - 4'd2) : (w_mon + 4'd10);
    end

    // stage 2 helpers
    always_comb begin
        w_q100p = 16'(r_yoff1) * 16'd41;
        w_q100  = w_q100p[14:12];
        n_leap  = 8'(r_yoff1[9:2]) - 8'(w_q100) + ((r_yoff1 >= 10'd400) ? 8'd1 : 8'd0);
        n_tsec  = 18'(r_hour1) * 18'd3600 + 18'(r_min1) * 18'd60 + 18'(r_sec1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_snap.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sec1  <= n_sec;
            r_min1  <= n_min;
            r_hour1 <= n_hour;
            r_mday1 <= n_mday;
            r_yoff1 <= n_yoff;
            r_mp1   <= n_mp;

            r_y365  <= 18'(r_yoff1) * 18'd365;
            r_leap  <= n_leap;
            r_doy   <= bcd2ns_pkg::doy_of(r_mp1);
            r_mday2 <= r_mday1;
            r_tsec2 <= n_tsec;

            r_days  <= 17'(r_y365 + 18'(r_leap) + 18'(r_doy) + 18'(r_mday2)
                           - bcd2ns_pkg::DAY_BIAS);
            r_tsec3 <= r_tsec2;

            r_total <= 34'(r_days) * 34'(bcd2ns_pkg::SEC_PER_DAY) + 34'(r_tsec3);

            r_sat <= (r_total > bcd2ns_pkg::SEC_LIMIT);
            r_plo <= 47'(r_total[bcd2ns_pkg::HALF_W-1:0]) * 47'(bcd2ns_pkg::NS_PER_SEC);
            r_phi <= 47'(r_total[bcd2ns_pkg::TOTAL_W-1:bcd2ns_pkg::HALF_W])
                   * 47'(bcd2ns_pkg::NS_PER_SEC);

            r_ns <= r_sat ? bcd2ns_pkg::RESULT_LIMIT
                          : 63'({r_phi, 17'd0}) + 63'(r_plo);
        end
    end

    `BCD2NS_ASSERT_NEXT(a_accept_enters, i_snap.valid && i_snap.ready, r_vld[0])
    `BCD2NS_ASSERT_NOW(a_result_limit, o_time.valid,
        o_time.epoch_nanoseconds <= bcd2ns_pkg::RESULT_LIMIT)
    `BCD2NS_ASSERT_NEXT(a_stall_freezes, o_time.valid && !o_time.ready,
        r_vld == $past(r_vld) && $stable(r_ns))

endmodule

`default_nettype wire

// ===== tb/tb_bcd_clock_to_epoch_nanoseconds.sv =====
// ----------------------------------------------------------------------------
// tb_bcd_clock_to_epoch_nanoseconds
// Self-checking bench for the RTC snapshot to epoch nanoseconds converter.
// Directed corner snapshots come first: 12-hour edges, rollover of every field,
// leap days, century bit and saturation. Random snapshots follow, mostly valid
// dates with some raw noise. They run under four flow-control phases. Each
// transfer is predicted in the bench and checked in order on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bcd_clock_to_epoch_nanoseconds;

    localparam logic [7:0]  HOUR_12H      = 8'h40;
    localparam logic [7:0]  HOUR_PM       = 8'h20;
    localparam logic [7:0]  CENTURY_BIT   = 8'h80;
    localparam longint      SEC_CAP       = 64'd7400000000;
    localparam longint      NS_CAP        = 64'd7400000000000000000;
    localparam longint      NS_PER_SECOND = 64'd1000000000;
    localparam int          RANDOM_PER_PHASE = 475;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES  = 20;

    typedef struct {
        logic [7:0] seconds;
        logic [7:0] minutes;
        logic [7:0] hours;
        logic [7:0] date;
        logic [7:0] month;
        logic [7:0] year;
        bit         hold;
    } snap_item_t;

    logic i_clk;
    logic i_rst_n;

    bcd2ns_in_if  snap ();
    bcd2ns_out_if epoch ();

    bcd_clock_to_epoch_nanoseconds dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_snap  (snap),
        .o_time  (epoch)
    );

    snap_item_t        pending_snaps[$];
    logic [62:0]       expected_ns[$];
    int                in_flight;
    int                idle_pct;
    int                stall_pct;
    int                errors;
    int                quiet_cycles;

    function automatic longint bcd_of(input logic [7:0] v);
        return longint'(v[3:0]) + 10 * longint'(v[7:4]);
    endfunction

    function automatic logic [7:0] to_bcd(input int unsigned n);
        return {4'(n / 10), 4'(n % 10)};
    endfunction

    function automatic logic [62:0] epoch_ns_of(input logic [7:0] sec_b, min_b,
                                                hr, dt, mc, yr);
        longint sec, minute, hour, mday, mon, year;
        longint m, yy, era, yoe, mp, doy, doe, days, total;
        sec    = bcd_of(sec_b);
        minute = bcd_of(min_b);
        hour   = longint'(hr[3:0]) + (hr[4] ? 10 : 0);
        mday   = bcd_of({2'b00, dt[5:0]});
        mon    = bcd_of({3'b000, mc[4:0]}) - 1;
        year   = 2000 + bcd_of(yr) + (mc[7] ? 100 : 0);
        if (hr[6]) begin
            if (hour == 12)
                hour = 0;
            if (hr[5])
                hour += 12;
        end else if (hr[5]) begin
            hour += 20;
        end
        if (mon < 0) begin
            mon += 12;
            year -= 1;
        end
        while (mon >= 12) begin
            mon -= 12;
            year += 1;
        end
        // civil date to day count, March-based year
        m    = mon + 1;
        yy   = (m <= 2) ? year - 1 : year;
        era  = yy / 400;
        yoe  = yy - era * 400;
        mp   = (m > 2) ? m - 3 : m + 9;
        doy  = (153 * mp + 2) / 5;
        doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = era * 146097 + doe - 719468 + mday - 1;
        total = days * 86400 + hour * 3600 + minute * 60 + sec;
        if (total < 0)
            total = 0;
        if (total > SEC_CAP)
            return NS_CAP[62:0];
        total = total * NS_PER_SECOND;
        if (total > NS_CAP)
            return NS_CAP[62:0];
        return total[62:0];
    endfunction

    task automatic add_snap(input logic [7:0] s, m, h, d, mc, y, input bit hold = 1'b0);
        snap_item_t it;
        it.seconds = s;
        it.minutes = m;
        it.hours   = h;
        it.date    = d;
        it.month   = mc;
        it.year    = y;
        it.hold    = hold;
        pending_snaps.push_back(it);
    endtask

    task automatic add_random(input bit hold);
        logic [7:0] h;
        if ($urandom_range(9) < 7) begin
            if ($urandom_range(1)) begin
                h = HOUR_12H | to_bcd($urandom_range(1, 12));
                if ($urandom_range(1))
                    h = h | HOUR_PM;
            end else begin
                h = to_bcd($urandom_range(0, 23));
            end
            h[7] = 1'($urandom_range(1));
            add_snap(to_bcd($urandom_range(0, 59)), to_bcd($urandom_range(0, 59)), h,
                     to_bcd($urandom_range(1, 31)) | {2'($urandom_range(3)), 6'd0},
                     to_bcd($urandom_range(1, 12)) | {3'($urandom_range(7)), 5'd0},
                     to_bcd($urandom_range(0, 99)), hold);
        end else begin
            add_snap(8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)), hold);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // snapshot driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            snap.valid <= 1'b0;
        end else if (!snap.valid || snap.ready) begin
            if (pending_snaps.size() != 0 && $urandom_range(99) >= idle_pct
                && (!pending_snaps[0].hold || (!snap.valid && in_flight == 0))) begin
                snap.valid         <= 1'b1;
                snap.seconds_bcd   <= pending_snaps[0].seconds;
                snap.minutes_bcd   <= pending_snaps[0].minutes;
                snap.hours_code    <= pending_snaps[0].hours;
                snap.date_bcd      <= pending_snaps[0].date;
                snap.month_century <= pending_snaps[0].month;
                snap.year_bcd      <= pending_snaps[0].year;
                pending_snaps.delete(0);
            end else begin
                snap.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        epoch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // result monitor and scoreboard
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_flight    <= 0;
            quiet_cycles <= 0;
        end else begin
            if (epoch.valid && epoch.ready) begin
                if (expected_ns.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, actual %0d", $time,
                             epoch.epoch_nanoseconds);
                end else if (expected_ns[0] !== epoch.epoch_nanoseconds) begin
                    errors++;
                    $display("%0t: epoch_nanoseconds mismatch, expected %0d, actual %0d",
                             $time, expected_ns[0], epoch.epoch_nanoseconds);
                    expected_ns.delete(0);
                end else begin
                    expected_ns.delete(0);
                end
            end
            if (snap.valid && snap.ready)
                expected_ns.push_back(epoch_ns_of(snap.seconds_bcd, snap.minutes_bcd,
                                                  snap.hours_code, snap.date_bcd,
                                                  snap.month_century, snap.year_bcd));
            in_flight <= in_flight + int'(snap.valid && snap.ready)
                                   - int'(epoch.valid && epoch.ready);
            if ((snap.valid && snap.ready) || (epoch.valid && epoch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_bcd_clock_to_epoch_nanoseconds: FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        snap.valid          = 1'b0;
        snap.seconds_bcd    = 8'h00;
        snap.minutes_bcd    = 8'h00;
        snap.hours_code     = 8'h00;
        snap.date_bcd       = 8'h00;
        snap.month_century  = 8'h00;
        snap.year_bcd       = 8'h00;
        epoch.ready         = 1'b0;
        idle_pct            = 0;
        stall_pct           = 0;
        errors              = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        add_snap(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        add_snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00);
        add_snap(8'h00, 8'h00, HOUR_12H | 8'h12, 8'h15, 8'h06, 8'h24);
        add_snap(8'h00, 8'h00, HOUR_12H | HOUR_PM | 8'h12, 8'h15, 8'h06, 8'h24);
        add_snap(8'h30, 8'h45, HOUR_12H | HOUR_PM | 8'h11, 8'h15, 8'h06, 8'h24);
        add_snap(8'h30, 8'h45, HOUR_12H | 8'h01, 8'h15, 8'h06, 8'h24);
        add_snap(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99);
        add_snap(8'h00, 8'h00, 8'h3f, 8'h10, 8'h05, 8'h10);
        add_snap(8'h00, 8'h00, HOUR_12H | HOUR_PM | 8'h1f, 8'h10, 8'h05, 8'h10);
        add_snap(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00);
        add_snap(8'h00, 8'h00, 8'h00, 8'h29, CENTURY_BIT | 8'h02, 8'h00);
        add_snap(8'h00, 8'h00, 8'h00, 8'h31, 8'h04, 8'h21);
        add_snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h21);
        add_snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h00);
        add_snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h1f, 8'h99);
        add_snap(8'h59, 8'h59, 8'h23, 8'h31, CENTURY_BIT | 8'h12, 8'h99);
        add_snap(8'h00, 8'h00, 8'h00, 8'h01, CENTURY_BIT | 8'h06, 8'ha4);
        add_snap(8'h00, 8'h00, 8'h00, 8'h01, CENTURY_BIT | 8'h08, 8'ha4);
        add_snap(8'h00, 8'h00, 8'h00, 8'h01, CENTURY_BIT | 8'h01, 8'hff);
        add_snap(8'hff, 8'hfa, 8'h0f, 8'h3f, 8'h0f, 8'hab);
        add_snap(8'h07, 8'h08, 8'h80 | 8'h12, 8'hc5, 8'h60 | 8'h03, 8'h42);

        for (int phase = 0; phase < 4; phase++) begin
            @(negedge i_clk);
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 62; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                add_random(n == RANDOM_PER_PHASE / 2 || $urandom_range(199) == 0);
            while (pending_snaps.size() != 0 || snap.valid || in_flight != 0)
                @(negedge i_clk);
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_ns.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, expected_ns.size());
        end
        if (errors == 0)
            $display("tb_bcd_clock_to_epoch_nanoseconds: PASS");
        else
            $display("tb_bcd_clock_to_epoch_nanoseconds: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== bcd_clock_to_epoch_nanoseconds.f =====
+incdir+sv
sv/bcd2ns_pkg.sv
sv/bcd2ns_in_if.sv
sv/bcd2ns_out_if.sv
sv/bcd_clock_to_epoch_nanoseconds.sv
tb/tb_bcd_clock_to_epoch_nanoseconds.sv
